// ===== rtl/xtea_pkg.sv =====
// Shared types, constants and helper functions for the XTEA cipher core.
// Used by xtea_cell and xtea_block_cipher_core; no dependencies.
package xtea_pkg;

  localparam int unsigned ROUNDS   = 32;
  localparam int unsigned STAGES   = 2 * ROUNDS;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] XTEA_DELTA    = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] XTEA_DEC_SUM  = WORD_W'(64'(XTEA_DELTA) * 64'(ROUNDS));

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] KEY_IDX_W0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_W1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_W2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_W3 = 3'd3;

  typedef logic [3:0][WORD_W-1:0] xtea_key_t;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] block_first;
    logic [WORD_W-1:0] block_second;
  } xtea_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_first;
    logic [WORD_W-1:0] out_second;
  } xtea_out_t;

  // Working state of one item as it moves down the cell chain.
  typedef struct packed {
    logic              op;
    logic              half;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] sum;
  } xtea_stage_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

// ===== rtl/xtea_cell.sv =====
// One XTEA half-round cell: updates one block word and, on the first half of each round, the running sum.
// Depends on xtea_pkg.
module xtea_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  xtea_pkg::xtea_key_t  key,
  input  logic                 vld_in,
  input  xtea_pkg::xtea_stage_t stg_in,
  output logic                 vld_out,
  output xtea_pkg::xtea_stage_t stg_out
);
  import xtea_pkg::*;

  logic        vld_r;
  xtea_stage_t stg_r;
  xtea_stage_t stg_nxt;
  logic [WORD_W-1:0] t_a;
  logic [WORD_W-1:0] t_b;

  always_comb begin
    t_a = mix(stg_in.b) ^ (stg_in.sum + key[stg_in.sum[1:0]]);
    t_b = mix(stg_in.a) ^ (stg_in.sum + key[stg_in.sum[12:11]]);
    stg_nxt      = stg_in;
    stg_nxt.half = ~stg_in.half;
    if (stg_in.op == OP_ENC) begin
      if (!stg_in.half) begin
        stg_nxt.a   = stg_in.a + t_a;
        stg_nxt.sum = stg_in.sum + XTEA_DELTA;
      end else begin
        stg_nxt.b = stg_in.b + t_b;
      end
    end else begin
      if (!stg_in.half) begin
        stg_nxt.b   = stg_in.b - t_b;
        stg_nxt.sum = stg_in.sum - XTEA_DELTA;
      end else begin
        stg_nxt.a = stg_in.a - t_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign vld_out = vld_r;
  assign stg_out = stg_r;

endmodule

// ===== rtl/xtea_block_cipher_core.sv =====
// XTEA block cipher core: key registers and a chain of half-round cells.
// Depends on xtea_pkg and xtea_cell.
//
// One 64-bit block item is accepted per clock cycle while in_ready is high;
// each item passes through every half-round cell of the chain, one register
// per cell, the last cell being the output register. While a finished
// result waits on out_ready the whole chain holds and in_ready is low. Block
// words are byte-reversed on entry and exit. Key words are written through the
// cfg port at indexes 0..3; other indexes are ignored. Change the key only
// while no item is in flight.
module xtea_block_cipher_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  xtea_pkg::xtea_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output xtea_pkg::xtea_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0] cfg_wdata
);
  import xtea_pkg::*;

  xtea_key_t   key_r;
  logic        adv;
  logic [STAGES:0] vld;
  xtea_stage_t stg [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        KEY_IDX_W0: key_r[0] <= cfg_wdata;
        KEY_IDX_W1: key_r[1] <= cfg_wdata;
        KEY_IDX_W2: key_r[2] <= cfg_wdata;
        KEY_IDX_W3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !vld[STAGES] || out_ready;
  assign in_ready = adv;

  always_comb begin
    vld[0]      = in_valid;
    stg[0].op   = in_data.op;
    stg[0].half = 1'b0;
    stg[0].a    = swap_bytes(in_data.block_first);
    stg[0].b    = swap_bytes(in_data.block_second);
    stg[0].sum  = (in_data.op == OP_DEC) ? XTEA_DEC_SUM : '0;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    xtea_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .key    (key_r),
      .vld_in (vld[i]),
      .stg_in (stg[i]),
      .vld_out(vld[i+1]),
      .stg_out(stg[i+1])
    );
  end

  assign out_valid          = vld[STAGES];
  assign out_data.out_first  = swap_bytes(stg[STAGES].a);
  assign out_data.out_second = swap_bytes(stg[STAGES].b);

`ifndef ASSERT_OFF
  a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld[STAGES:1]))
    else $error("cell chain moved while stalled");

  a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld[1])
    else $error("accepted item missing from first cell");

  a_out_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (stg[STAGES].half == 1'b0))
    else $error("result leaves on a half round");

  a_out_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((stg[STAGES].op == OP_ENC && stg[STAGES].sum == XTEA_DEC_SUM) ||
                   (stg[STAGES].op == OP_DEC && stg[STAGES].sum == '0)))
    else $error("running sum wrong at chain end");
`endif

endmodule

// ===== verif/xtea_check_pkg.sv =====
// Result tracker for the XTEA core testbench: predicts each block's cipher
// output from a local key copy and matches results in order. Needs xtea_pkg.
package xtea_check_pkg;
  import xtea_pkg::*;

  localparam logic [31:0] GOLDEN_DELTA = 32'h9E37_79B9;

  class xtea_result_tracker;
    logic [31:0] key_word [4];
    xtea_out_t   expected_blocks [$];
    int unsigned blocks_in;
    int unsigned blocks_out;
    int unsigned failures;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      blocks_in  = 0;
      blocks_out = 0;
      failures   = 0;
    endfunction

    function logic [31:0] round_mix(logic [31:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    function xtea_out_t transform(xtea_in_t blk);
      logic [31:0] v0, v1, acc;
      xtea_out_t   res;
      v0 = {<<8{blk.block_first}};
      v1 = {<<8{blk.block_second}};
      acc = '0;
      if (blk.op == OP_ENC) begin
        repeat (ROUNDS) begin
          v0 += round_mix(v1) ^ (acc + key_word[acc[1:0]]);
          acc += GOLDEN_DELTA;
          v1 += round_mix(v0) ^ (acc + key_word[acc[12:11]]);
        end
      end else begin
        repeat (ROUNDS) acc += GOLDEN_DELTA;
        repeat (ROUNDS) begin
          v1 -= round_mix(v0) ^ (acc + key_word[acc[12:11]]);
          acc -= GOLDEN_DELTA;
          v0 -= round_mix(v1) ^ (acc + key_word[acc[1:0]]);
        end
      end
      res.out_first  = {<<8{v0}};
      res.out_second = {<<8{v1}};
      return res;
    endfunction

    function void note_key_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      if (idx <= KEY_IDX_W3) key_word[idx[1:0]] = data;
    endfunction

    function void note_block(xtea_in_t blk);
      expected_blocks.push_back(transform(blk));
      blocks_in++;
    endfunction

    function void check_block(xtea_out_t got);
      xtea_out_t want;
      blocks_out++;
      if (expected_blocks.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result %0d: %h %h", blocks_out, got.out_first, got.out_second);
        return;
      end
      want = expected_blocks.pop_front();
      if (got.out_first !== want.out_first || got.out_second !== want.out_second) begin
        failures++;
        if (failures <= 10)
          $display("result %0d mismatch: out_first exp %h got %h, out_second exp %h got %h",
                   blocks_out, want.out_first, got.out_first, want.out_second,
                   got.out_second);
      end
    endfunction

    function void close_out();
      if (expected_blocks.size() != 0) begin
        failures += expected_blocks.size();
        $display("%0d results never arrived", expected_blocks.size());
      end
    endfunction
  endclass

endpackage

// ===== verif/tb.sv =====
// Top-level testbench for xtea_block_cipher_core: directed and random blocks
// under several keys and idle patterns. Needs xtea_pkg and xtea_check_pkg.
module tb;
  import xtea_pkg::*;
  import xtea_check_pkg::*;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = STAGES + 8;
  localparam int unsigned PHASE_ITEMS  = 250;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  xtea_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  xtea_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  xtea_result_tracker tracker;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        stall_cycles;
  int unsigned        key_settings;

  xtea_block_cipher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_block(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles with no item moving", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_block(input xtea_in_t blk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= {1'($urandom), $urandom, $urandom};
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_block(blk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.note_key_write(idx, data);
  endtask

  // key words first, then junk into the unused indexes, which must be ignored
  task automatic program_key(input logic [WORD_W-1:0] k0, k1, k2, k3);
    logic [CFG_IDX_W-1:0] idx;
    cfg_write(KEY_IDX_W0, k0);
    cfg_write(KEY_IDX_W1, k1);
    cfg_write(KEY_IDX_W2, k2);
    cfg_write(KEY_IDX_W3, k3);
    idx = KEY_IDX_W3 + 1'b1;
    do begin
      cfg_write(idx, $urandom);
      idx++;
    end while (idx != '0);
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  task automatic settle_pipeline(input int unsigned extra);
    while (tracker.expected_blocks.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    logic [31:0] pat_a [7] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                               32'h8000_0000, 32'h0123_4567, 32'hAAAA_AAAA};
    logic [31:0] pat_b [7] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                               32'h0000_0001, 32'h89AB_CDEF, 32'h5555_5555};
    xtea_in_t  blk;
    xtea_out_t ct;
    for (int i = 0; i < 7; i++) begin
      blk.block_first  = pat_a[i];
      blk.block_second = pat_b[i];
      blk.op = OP_ENC;
      send_block(blk);
      blk.op = OP_DEC;
      send_block(blk);
    end
    // round trips in both directions
    blk = '{op: OP_ENC, block_first: 32'hDEAD_BEEF, block_second: 32'h0BAD_F00D};
    send_block(blk);
    ct = tracker.transform(blk);
    send_block('{op: OP_DEC, block_first: ct.out_first, block_second: ct.out_second});
    blk.op = OP_DEC;
    send_block(blk);
    ct = tracker.transform(blk);
    send_block('{op: OP_ENC, block_first: ct.out_first, block_second: ct.out_second});
  endtask

  task automatic run_random(input int unsigned count);
    xtea_in_t    blk;
    xtea_out_t   prev_out;
    logic        prev_op;
    logic        have_prev;
    int unsigned pick;
    have_prev = 1'b0;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2 && have_prev) begin
        blk.op           = ~prev_op;
        blk.block_first  = prev_out.out_first;
        blk.block_second = prev_out.out_second;
      end else if (pick == 3) begin
        blk.op           = 1'($urandom_range(0, 1));
        blk.block_first  = extreme_word();
        blk.block_second = extreme_word();
      end else begin
        blk.op           = 1'($urandom_range(0, 1));
        blk.block_first  = $urandom;
        blk.block_second = $urandom;
      end
      prev_out  = tracker.transform(blk);
      prev_op   = blk.op;
      have_prev = 1'b1;
      send_block(blk);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    tracker       = new();
    send_idle_pct = 14;
    recv_idle_pct = 72;
    stall_cycles  = 0;
    key_settings  = 1;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= KEY_IDX_W0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key (all zero) first
    run_directed();
    run_random(PHASE_ITEMS);

    for (int phase = 1; phase <= 5; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 14;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle_pipeline(4);
      case (phase)
        1:       program_key('1, '1, '1, '1);
        3:       program_key(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE);
        5:       program_key('0, '0, '0, '0);
        default: program_key($urandom, $urandom, $urandom, $urandom);
      endcase
      run_random(PHASE_ITEMS);
    end

    settle_pipeline(DRAIN_CYCLES);
    tracker.close_out();
    $display("Covered %0d blocks in both directions under %0d key settings and three idle mixes",
             tracker.blocks_in, key_settings);
    $display("Checked %0d results, %0d failures", tracker.blocks_out, tracker.failures);
    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== xtea_block_cipher_core.f =====
rtl/xtea_pkg.sv
rtl/xtea_cell.sv
rtl/xtea_block_cipher_core.sv
verif/xtea_check_pkg.sv
verif/tb.sv
